@@ design/tccw_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Text console character writer package
// Geometry, field widths, character codes and the control and status bundles
// shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package tccw_pkg;

    localparam int MAX_COLUMNS = 80;
    localparam int MAX_ROWS    = 25;
    localparam int STORE_DEPTH = MAX_COLUMNS * MAX_ROWS;

    localparam int ADDR_W     = 11;
    localparam int ROW_W      = 5;
    localparam int COL_W      = 7;
    localparam int CELL_W     = 16;
    localparam int CHAR_W     = 8;
    localparam int COLOR_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR = 2'd2;

    localparam logic [CHAR_W-1:0]  CH_BACKSPACE  = 8'h08;
    localparam logic [CHAR_W-1:0]  CH_NEWLINE    = 8'h0A;
    localparam logic [CHAR_W-1:0]  CH_BLANK      = 8'h20;
    localparam logic [COLOR_W-1:0] RESET_COLOR   = 8'h07;
    localparam logic [COL_W-1:0]   RESET_COLUMNS = 7'd80;
    localparam logic [ROW_W-1:0]   RESET_ROWS    = 5'd25;

    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic exec;
        logic read_cap;
        logic cell_wr;
        logic scroll_start;
        logic scroll_rd;
        logic scroll_wr;
        logic scroll_blank;
        logic out_load;
    } tccw_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic is_read;
        logic need_scroll;
        logic copy_more;
        logic blank_more;
        logic out_free;
    } tccw_status_t;

endpackage
`default_nettype wire

@@ design/tccw_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ design/tccw_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Text console character writer controller
// Sequences the clearing pass, item decode, cell write or read capture, scroll
// copy and blanking, and result hand-off.
// ----------------------------------------------------------------------------
module tccw_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire tccw_pkg::tccw_status_t status,
    output tccw_pkg::tccw_cmd_t         cmd
);
    import tccw_pkg::*;

    typedef enum logic [7:0] {
        ST_CLEAR   = 8'b0000_0001,
        ST_IDLE    = 8'b0000_0010,
        ST_EXEC    = 8'b0000_0100,
        ST_RD_WAIT = 8'b0000_1000,
        ST_WRITE   = 8'b0001_0000,
        ST_SCRL_RD = 8'b0010_0000,
        ST_SCRL_WR = 8'b0100_0000,
        ST_FINISH  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = status.is_read ? ST_RD_WAIT : ST_WRITE;
            end
            ST_RD_WAIT: begin
                cmd.read_cap = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_WRITE: begin
                cmd.cell_wr = 1'b1;
                if (status.need_scroll) begin
                    cmd.scroll_start = 1'b1;
                    state_next       = ST_SCRL_RD;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_SCRL_RD: begin
                if (status.copy_more) begin
                    cmd.scroll_rd = 1'b1;
                    state_next    = ST_SCRL_WR;
                end else if (status.blank_more) begin
                    cmd.scroll_blank = 1'b1;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_SCRL_WR: begin
                cmd.scroll_wr = 1'b1;
                state_next    = ST_SCRL_RD;
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ design/tccw_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Text console character writer datapath
// Configuration registers, cursor, screen store, scroll counters and the
// result register.
// ----------------------------------------------------------------------------
module tccw_datapath (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [tccw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [tccw_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             s_tuser,
    input  wire logic [tccw_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [tccw_pkg::M_TDATA_W-1:0]   m_tdata,
    input  wire tccw_pkg::tccw_cmd_t              cmd,
    output tccw_pkg::tccw_status_t                status
);
    import tccw_pkg::*;

    localparam int PROD_W = ROW_W + COL_W;

    logic [COL_W-1:0]   columns_reg;
    logic [ROW_W-1:0]   rows_reg;
    logic [COLOR_W-1:0] color_reg;
    logic [COL_W-1:0]   nc_used;
    logic [ROW_W-1:0]   nr_used;
    logic [ADDR_W-1:0]  copy_end_reg, store_end_reg;
    logic [PROD_W-1:0]  copy_prod, store_prod, wr_prod, pos_prod;

    logic               kind_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic [ADDR_W-1:0]  idx_reg;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   wr_row_reg, wr_row_next;
    logic [COL_W-1:0]   wr_col_reg, wr_col_next;
    logic [CHAR_W-1:0]  wr_char_reg;
    logic               no_write_reg;
    logic               rd_oob_reg;
    logic [CELL_W-1:0]  cell_reg;
    logic [ADDR_W-1:0]  dst_reg, src_reg;

    logic               m_tvalid_reg;
    logic [CELL_W-1:0]  out_cell_reg;
    logic [ROW_W-1:0]   out_row_reg;
    logic [COL_W-1:0]   out_col_reg;
    logic [ADDR_W-1:0]  out_pos_reg;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [CELL_W-1:0]  ram_wdata, ram_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            columns_reg <= RESET_COLUMNS;
            rows_reg    <= RESET_ROWS;
            color_reg   <= RESET_COLOR;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_COLUMNS:    columns_reg <= cfg_data[COL_W-1:0];
                CFG_ROWS:       rows_reg    <= cfg_data[ROW_W-1:0];
                CFG_TEXT_COLOR: color_reg   <= cfg_data[COLOR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (columns_reg == '0) begin
            nc_used = COL_W'(1);
        end else if (columns_reg > COL_W'(MAX_COLUMNS)) begin
            nc_used = COL_W'(MAX_COLUMNS);
        end else begin
            nc_used = columns_reg;
        end
        if (rows_reg == '0) begin
            nr_used = ROW_W'(1);
        end else if (rows_reg > ROW_W'(MAX_ROWS)) begin
            nr_used = ROW_W'(MAX_ROWS);
        end else begin
            nr_used = rows_reg;
        end
    end

    assign copy_prod  = PROD_W'(nr_used - ROW_W'(1)) * PROD_W'(nc_used);
    assign store_prod = PROD_W'(nr_used) * PROD_W'(nc_used);
    assign wr_prod    = PROD_W'(wr_row_reg) * PROD_W'(nc_used) + PROD_W'(wr_col_reg);
    assign pos_prod   = PROD_W'(row_reg) * PROD_W'(nc_used) + PROD_W'(col_reg);

    always_ff @(posedge aclk) begin
        copy_end_reg  <= copy_prod[ADDR_W-1:0];
        store_end_reg <= store_prod[ADDR_W-1:0];
    end

    // Next cursor and target cell for a put item.
    always_comb begin
        row_next    = row_reg;
        col_next    = col_reg;
        wr_row_next = row_reg;
        wr_col_next = col_reg;
        if (char_reg == CH_BACKSPACE) begin
            if (col_reg == '0 && row_reg != '0) begin
                wr_row_next = row_reg - ROW_W'(1);
                wr_col_next = nc_used - COL_W'(1);
            end else if (col_reg != '0) begin
                wr_col_next = col_reg - COL_W'(1);
            end
            row_next = wr_row_next;
            col_next = wr_col_next;
        end else if (char_reg == CH_NEWLINE) begin
            col_next = '0;
            row_next = row_reg + ROW_W'(1);
        end else if (col_reg + COL_W'(1) >= nc_used) begin
            col_next = '0;
            row_next = row_reg + ROW_W'(1);
        end else begin
            col_next = col_reg + COL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
            dst_reg <= '0;
        end else begin
            if (cmd.clear_wr) begin
                dst_reg <= dst_reg + ADDR_W'(1);
            end
            if (cmd.accept) begin
                row_reg <= (row_reg > nr_used - ROW_W'(1)) ? nr_used - ROW_W'(1) : row_reg;
                col_reg <= (col_reg > nc_used - COL_W'(1)) ? nc_used - COL_W'(1) : col_reg;
            end
            if (cmd.exec && !kind_reg) begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
            if (cmd.scroll_start) begin
                row_reg <= nr_used - ROW_W'(1);
                dst_reg <= '0;
            end
            if (cmd.scroll_wr || cmd.scroll_blank) begin
                dst_reg <= dst_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            kind_reg <= s_tuser;
            char_reg <= s_tdata[CHAR_W-1:0];
            idx_reg  <= s_tdata[CHAR_W +: ADDR_W];
            cell_reg <= '0;
        end
        if (cmd.exec) begin
            wr_row_reg   <= wr_row_next;
            wr_col_reg   <= wr_col_next;
            wr_char_reg  <= (char_reg == CH_BACKSPACE) ? CH_BLANK : char_reg;
            no_write_reg <= (char_reg == CH_NEWLINE);
            rd_oob_reg   <= (idx_reg >= ADDR_W'(STORE_DEPTH));
        end
        if (cmd.read_cap) begin
            cell_reg <= rd_oob_reg ? '0 : ram_rdata;
        end
        if (cmd.scroll_start) begin
            src_reg <= ADDR_W'(nc_used);
        end
        if (cmd.scroll_wr) begin
            src_reg <= src_reg + ADDR_W'(1);
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = dst_reg;
        ram_wdata = {RESET_COLOR, CH_BLANK};
        if (cmd.cell_wr && !no_write_reg) begin
            ram_we    = 1'b1;
            ram_waddr = wr_prod[ADDR_W-1:0];
            ram_wdata = {color_reg, wr_char_reg};
        end else if (cmd.scroll_wr) begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
        end else if (cmd.scroll_blank) begin
            ram_we    = 1'b1;
            ram_wdata = {color_reg, CH_BLANK};
        end else if (cmd.clear_wr) begin
            ram_we = 1'b1;
        end
        ram_raddr = cmd.scroll_rd ? src_reg : idx_reg;
    end

    tccw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_cell_reg <= cell_reg;
            out_row_reg  <= row_reg;
            out_col_reg  <= col_reg;
            out_pos_reg  <= pos_prod[ADDR_W-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_pos_reg, out_col_reg, out_row_reg, out_cell_reg};

    assign status.clear_last  = (dst_reg == ADDR_W'(STORE_DEPTH - 1));
    assign status.is_read     = kind_reg;
    assign status.need_scroll = (row_reg >= nr_used);
    assign status.copy_more   = (dst_reg < copy_end_reg);
    assign status.blank_more  = (dst_reg < store_end_reg);
    assign status.out_free    = !m_tvalid_reg || m_tready;

endmodule
`default_nettype wire

@@ design/text_console_char_writer_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Text console character writer
// Puts characters into an 80 by 25 character-cell screen store, moves the
// cursor, scrolls and reads back single cells.
// ----------------------------------------------------------------------------
// A result is presented once its word has passed the accept, decode, store
// access and result load steps in turn, with a scroll copy and blanking pass
// before the result load when the item scrolls the screen. A new word is taken
// only after the result of the previous one has been loaded.
// Reset: synchronous, active low; afterwards a clearing pass fills
// the store with blank cells of color 0x07 while no word is accepted.
module text_console_char_writer_top (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [tccw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [tccw_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // char_code [7:0], cell_index [18:8], zero [23:19]
    input  wire logic [tccw_pkg::S_TDATA_W-1:0]   s_tdata,
    // kind [0]
    input  wire logic                             s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // read_cell [15:0], cursor_row [20:16], cursor_column [27:21],
    // cursor_position [38:28], zero [39]
    output logic      [tccw_pkg::M_TDATA_W-1:0]   m_tdata
);
    import tccw_pkg::*;

    tccw_cmd_t    cmd;
    tccw_status_t status;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;

    tccw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tccw_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

    assign out_row = m_tdata[CELL_W +: ROW_W];
    assign out_col = m_tdata[CELL_W + ROW_W +: COL_W];

    a_one_word_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("A second word was taken while one is in progress.");

    a_cursor_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_row < ROW_W'(MAX_ROWS)) && (out_col < COL_W'(MAX_COLUMNS)))
        else $error("Reported cursor lies outside the screen.");

    a_copy_follows_read: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scroll_wr |-> $past(cmd.scroll_rd))
        else $error("Scroll copy wrote without a preceding read.");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_tvalid)
        else $error("Result was not presented after loading.");

endmodule
`default_nettype wire
